// File: design/bf_fnv_pkg.sv
// Shared types, constants and the FNV-1a step function of the Bloom filter core.
package bf_fnv_pkg;

  // Filter geometry. The probe index is taken from the low bits of the hash
  // sum, so FILTER_BITS is kept to a power of two.
  localparam int FILTER_BITS = 1024;
  localparam int HASH_COUNT  = 3;
  localparam int IDX_W       = $clog2(FILTER_BITS);
  localparam int STORE_BYTES = (FILTER_BITS + 7) / 8;
  localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int K_W         = (HASH_COUNT > 1) ? $clog2(HASH_COUNT) : 1;

  // Field widths fixed by the interface.
  localparam int KEY_W  = 64;
  localparam int BYTE_W = 8;
  localparam int BIDX_W = 7;
  localparam int CMD_W  = 3;

  // FNV-1a 64: one octet per step, eight steps per key.
  localparam int                OCTETS     = KEY_W / BYTE_W;
  localparam int                OCT_CNT_W  = $clog2(OCTETS);
  localparam logic [KEY_W-1:0]  FNV_OFFSET = 64'hcbf29ce484222325;
  // The prime 0x100000001b3 is split into 2^40 plus a small low part,
  // so the product is a shift and a handful of shifted adds.
  localparam int                FNV_PRIME_SHIFT = 40;
  localparam int                FNV_LO_W        = 9;
  localparam logic [FNV_LO_W-1:0] FNV_PRIME_LO  = 9'h1b3;
  localparam logic [BYTE_W-1:0] BYTE_MASK  = 8'hFF;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

  // Configuration port: 64-bit registers on 8-byte slots; only slot 0 (the salt) is used.
  localparam int   CFG_AW   = 4;
  localparam int   CFG_DW   = 64;
  localparam logic REG_SALT = 1'b0;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [KEY_W-1:0]  node_id;
    logic [BIDX_W-1:0] byte_index;
    logic [BYTE_W-1:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic              present;
    logic [BYTE_W-1:0] byte_out;
  } out_item_t;

  // Status handed from the hash unit to the controller.
  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] h1_idx;
    logic [IDX_W-1:0] h2_idx;
  } hash_res_t;

  // One FNV-1a round: XOR the octet in, then multiply by the prime mod 2^64.
  function automatic logic [KEY_W-1:0] fnv_step(input logic [KEY_W-1:0] h,
                                                input logic [BYTE_W-1:0] octet);
    logic [KEY_W-1:0] x;
    logic [KEY_W-1:0] acc;
    x   = h ^ {{(KEY_W-BYTE_W){1'b0}}, octet};
    acc = x << FNV_PRIME_SHIFT;
    for (int i = 0; i < FNV_LO_W; i++) begin
      if (FNV_PRIME_LO[i]) begin
        acc = acc + (x << i);
      end
    end
    return acc;
  endfunction

endpackage

// File: design/bf_fnv_ram.sv
// Generic single-port synchronous RAM with a registered read port.
module bf_fnv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // A write takes the port for the cycle; otherwise the addressed word is read.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/bf_fnv_hash.sv
// Iterative dual FNV-1a 64 unit: both hashes advance by one octet per cycle.
module bf_fnv_hash (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic [bf_fnv_pkg::KEY_W-1:0]  key,
  input  logic [bf_fnv_pkg::KEY_W-1:0]  salt,
  output bf_fnv_pkg::hash_res_t         res
);

  logic [bf_fnv_pkg::KEY_W-1:0]     h1_r;
  logic [bf_fnv_pkg::KEY_W-1:0]     h2_r;
  logic [bf_fnv_pkg::KEY_W-1:0]     k1_r;
  logic [bf_fnv_pkg::KEY_W-1:0]     k2_r;
  logic [bf_fnv_pkg::OCT_CNT_W-1:0] cnt_r;
  logic                             run_r;
  logic                             done_r;

  localparam logic [bf_fnv_pkg::OCT_CNT_W-1:0] CNT_LAST =
    bf_fnv_pkg::OCT_CNT_W'(bf_fnv_pkg::OCTETS - 1);

  // Control: a run steps through every octet and ends with a one-cycle done.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (load) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: the key is consumed most significant octet first.
  always_ff @(posedge clk) begin
    if (load) begin
      h1_r <= bf_fnv_pkg::FNV_OFFSET;
      h2_r <= bf_fnv_pkg::FNV_OFFSET;
      k1_r <= key;
      k2_r <= key ^ salt;
    end else if (run_r) begin
      h1_r <= bf_fnv_pkg::fnv_step(h1_r,
                k1_r[bf_fnv_pkg::KEY_W-1 -: bf_fnv_pkg::BYTE_W]);
      h2_r <= bf_fnv_pkg::fnv_step(h2_r,
                k2_r[bf_fnv_pkg::KEY_W-1 -: bf_fnv_pkg::BYTE_W]);
      k1_r <= k1_r << bf_fnv_pkg::BYTE_W;
      k2_r <= k2_r << bf_fnv_pkg::BYTE_W;
    end
  end

  // Only the low bits reach the probe logic, as the filter size is a power of two.
  assign res.done   = done_r;
  assign res.h1_idx = h1_r[bf_fnv_pkg::IDX_W-1:0];
  assign res.h2_idx = h2_r[bf_fnv_pkg::IDX_W-1:0];

endmodule

// File: design/bloom_filter_fnv1a_double_hash_core.sv
// Top level of the Bloom filter core: controller, hash unit, filter store and config register.
//
// Usage. A command is taken at a rising edge where start is high and busy is
// low; its fields arrive on in_item. Every command gives exactly one result:
// out_valid is high for one cycle with out_item, and the receiver cannot stall.
// Commands: clear, insert id, query id, write byte and read byte.
// Path from the accepting edge to the result:
//   clear, write byte, insert of id zero, unused codes: result registered directly;
//   read byte: one RAM read, then the result;
//   insert and query: the eight octet rounds of the hash unit, then HASH_COUNT
//   probes, each a read then a test or write-back on the single-port filter
//   RAM, then the result.
// busy stays high until the result has been presented, so the next command
// can be taken in the result cycle itself.
// The salt register sits on the APB port at byte address 0; pready is always
// high. Reset clears the per-byte valid flags, so the whole filter reads as
// zero straight away, and the salt returns to zero. Clear does the same to
// the filter and keeps the salt.
module bloom_filter_fnv1a_double_hash_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // Command channel
  input  logic                          start,
  output logic                          busy,
  input  bf_fnv_pkg::in_item_t          in_item,
  // Result channel
  output logic                          out_valid,
  output bf_fnv_pkg::out_item_t         out_item,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bf_fnv_pkg::CFG_AW-1:0] paddr,
  input  logic [bf_fnv_pkg::CFG_DW-1:0] pwdata,
  output logic [bf_fnv_pkg::CFG_DW-1:0] prdata,
  output logic                          pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_WAIT,
    S_HASH,
    S_PROBE_RD,
    S_PROBE_DATA
  } state_t;

  localparam logic [bf_fnv_pkg::K_W-1:0] K_LAST =
    bf_fnv_pkg::K_W'(bf_fnv_pkg::HASH_COUNT - 1);

  state_t                              state_r;
  logic                                out_valid_r;
  bf_fnv_pkg::out_item_t               out_item_r;
  logic                                insert_r;
  logic                                all_set_r;
  logic [bf_fnv_pkg::IDX_W-1:0]        idx_r;
  logic [bf_fnv_pkg::IDX_W-1:0]        stride_r;
  logic [bf_fnv_pkg::K_W-1:0]          k_r;
  logic [2:0]                          bit_sel_r;
  logic [bf_fnv_pkg::ADDR_W-1:0]       probe_addr_r;
  logic                                rd_valid_r;
  logic [bf_fnv_pkg::STORE_BYTES-1:0]  valid_r;
  logic [bf_fnv_pkg::KEY_W-1:0]        salt_r;

  logic                                accept;
  logic                                bidx_ok;
  logic [bf_fnv_pkg::ADDR_W-1:0]       bidx_addr;
  logic [bf_fnv_pkg::ADDR_W-1:0]       idx_addr;
  logic                                hash_load;
  bf_fnv_pkg::hash_res_t               hash_res;
  logic                                ram_en;
  logic                                ram_we;
  logic [bf_fnv_pkg::ADDR_W-1:0]       ram_addr;
  logic [bf_fnv_pkg::BYTE_W-1:0]       ram_wdata;
  logic [bf_fnv_pkg::BYTE_W-1:0]       ram_rdata;
  logic [bf_fnv_pkg::BYTE_W-1:0]       rd_byte;
  logic [bf_fnv_pkg::BYTE_W-1:0]       bit_mask;
  logic                                all_set_nxt;
  logic                                cfg_wr;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign bidx_ok   = 32'(in_item.byte_index) < 32'(bf_fnv_pkg::STORE_BYTES);
  assign bidx_addr = bf_fnv_pkg::ADDR_W'(in_item.byte_index);
  assign idx_addr  = bf_fnv_pkg::ADDR_W'(idx_r >> 3);
  assign hash_load = accept &&
                     ((in_item.command == bf_fnv_pkg::CMD_QUERY) ||
                      ((in_item.command == bf_fnv_pkg::CMD_INSERT) &&
                       (in_item.node_id != '0)));

  // A byte never written since reset or clear reads as zero.
  assign rd_byte     = rd_valid_r ? ram_rdata : '0;
  assign bit_mask    = bf_fnv_pkg::BYTE_W'(1) << bit_sel_r;
  assign all_set_nxt = all_set_r && (insert_r || rd_byte[bit_sel_r]);

  // RAM port: host byte access when idle, probe read, then write-back on insert.
  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = idx_addr;
    ram_wdata = in_item.byte_value;
    unique case (state_r)
      S_IDLE: begin
        if (accept && bidx_ok && (in_item.command == bf_fnv_pkg::CMD_WRITE)) begin
          ram_en   = 1'b1;
          ram_we   = 1'b1;
          ram_addr = bidx_addr;
        end else if (accept && bidx_ok &&
                     (in_item.command == bf_fnv_pkg::CMD_READ)) begin
          ram_en   = 1'b1;
          ram_addr = bidx_addr;
        end
      end
      S_PROBE_RD: begin
        ram_en = 1'b1;
      end
      S_PROBE_DATA: begin
        if (insert_r) begin
          ram_en    = 1'b1;
          ram_we    = 1'b1;
          ram_addr  = probe_addr_r;
          ram_wdata = rd_byte | bit_mask;
        end
      end
      default: begin
      end
    endcase
  end

  // Filter store.
  bf_fnv_ram #(
    .WIDTH (bf_fnv_pkg::BYTE_W),
    .DEPTH (bf_fnv_pkg::STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Hash unit for both FNV-1a hashes.
  bf_fnv_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (hash_load),
    .key   (in_item.node_id),
    .salt  (salt_r),
    .res   (hash_res)
  );

  // Valid flags: cleared as a whole by reset or clear, set by any store write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (accept && (in_item.command == bf_fnv_pkg::CMD_CLEAR)) begin
      valid_r <= '0;
    end else if (ram_en && ram_we) begin
      valid_r[ram_addr] <= 1'b1;
    end
  end

  // Salt register behind the APB port.
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[3] == bf_fnv_pkg::REG_SALT) ? salt_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      salt_r <= '0;
    end else if (cfg_wr && (paddr[3] == bf_fnv_pkg::REG_SALT)) begin
      salt_r <= pwdata;
    end
  end

  // Command sequencer with the registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      out_item_r  <= '0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (hash_load) begin
              state_r   <= S_HASH;
              insert_r  <= (in_item.command == bf_fnv_pkg::CMD_INSERT);
              all_set_r <= 1'b1;
            end else if (in_item.command == bf_fnv_pkg::CMD_READ) begin
              state_r    <= S_RD_WAIT;
              rd_valid_r <= bidx_ok && valid_r[bidx_addr];
            end else begin
              // Clear, write byte, insert of id zero and unused codes.
              out_valid_r <= 1'b1;
              out_item_r  <= '0;
            end
          end
        end
        S_RD_WAIT: begin
          out_valid_r         <= 1'b1;
          out_item_r.present  <= 1'b0;
          out_item_r.byte_out <= rd_byte;
          state_r             <= S_IDLE;
        end
        S_HASH: begin
          if (hash_res.done) begin
            idx_r    <= hash_res.h1_idx;
            stride_r <= hash_res.h2_idx;
            k_r      <= '0;
            state_r  <= S_PROBE_RD;
          end
        end
        S_PROBE_RD: begin
          probe_addr_r <= idx_addr;
          bit_sel_r    <= idx_r[2:0];
          rd_valid_r   <= valid_r[idx_addr];
          state_r      <= S_PROBE_DATA;
        end
        S_PROBE_DATA: begin
          all_set_r <= all_set_nxt;
          idx_r     <= idx_r + stride_r;
          if (k_r == K_LAST) begin
            out_valid_r         <= 1'b1;
            out_item_r.present  <= !insert_r && all_set_nxt;
            out_item_r.byte_out <= '0;
            state_r             <= S_IDLE;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_PROBE_RD;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: design/bf_fnv_checker.sv
// Port-level checker for the Bloom filter core, bound to the top level.
module bf_fnv_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // After reset the core is idle and shows no result.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("core not quiet after reset");

  // An accepted command either occupies the core or is answered at once.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted command neither busy nor answered");

  // A result is only shown once the core is free again.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // The core leaves busy only with the result of its command.
  a_busy_ends_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_valid)
    else $error("busy dropped without a result");

endmodule

bind bloom_filter_fnv1a_double_hash_core bf_fnv_checker u_bf_fnv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
